// ----- rtl/rgbct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rgbct_pkg;

    // Default fixed-point and sample widths.
    localparam int FRAC_BITS_DEF    = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Side information that rides along with an item behind the sums.
    typedef struct packed {
        logic        inval;
        logic        neg;
        logic        big;
        logic [15:0] lux;
        logic        lclip;
    } side_t;

    // Signed value in units of 1e-8, rounded to f fraction bits, half away from zero.
    function automatic longint quant_e8(longint v, int f);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = ((m <<< f) + 64'sd50000000) / 64'sd100000000;
        return (v < 0) ? -r : r;
    endfunction

    // Same, in units of 1e-9.
    function automatic longint quant_e9(longint v, int f);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = ((m <<< f) + 64'sd500000000) / 64'sd1000000000;
        return (v < 0) ? -r : r;
    endfunction

    // Same, in units of 1e-5.
    function automatic longint quant_e5(longint v, int f);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = ((m <<< f) + 64'sd50000) / 64'sd100000;
        return (v < 0) ? -r : r;
    endfunction

    // Same, in units of 1e-2.
    function automatic longint quant_e2(longint v, int f);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = ((m <<< f) + 64'sd50) / 64'sd100;
        return (v < 0) ? -r : r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rgb_color_temperature_lux.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Beat contents
// s_       | in        | red, green, blue sensor counts
// m_       | out       | color_temp, lux, temp_invalid, temp_clipped, lux_clipped
//
// One beat is accepted per cycle while m_ready is high or m_valid is low; the
// restoring divider resolves one quotient bit per stage (FRAC_BITS + 4 stages).
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// A stall on m_ready holds every stage in place, so nothing is lost or repeated.
module rgb_color_temperature_lux
    import rgbct_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [15:0] s_red,
    input  wire  [15:0] s_green,
    input  wire  [15:0] s_blue,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [15:0] m_color_temp,
    output logic [15:0] m_lux,
    output logic        m_temp_invalid,
    output logic        m_temp_clipped,
    output logic        m_lux_clipped
);

    localparam int F   = FRAC_BITS;
    localparam int CW  = F + 3;       // coefficient width, signed
    localparam int PW  = F + 20;      // coefficient times sample
    localparam int SW  = F + 22;      // sum of three products
    localparam int DS  = F + 4;       // divider stages
    localparam int NW  = F + 5;       // |n|, up to 16.0
    localparam int N2W = F + 9;       // n^2, up to 256.0
    localparam int N3W = F + 13;      // |n^3|, up to 4096.0
    localparam int TW  = F + 19;      // |6823.3 n|
    localparam int CTW = F + 26;      // polynomial sum, signed

    // Folded coefficients of the numerator, denominator and Y rows.
    localparam logic signed [CW-1:0] NUM_C0 = CW'(quant_e8(64'sd23881400, F));
    localparam logic signed [CW-1:0] NUM_C1 = CW'(quant_e8(64'sd25499112, F));
    localparam logic signed [CW-1:0] NUM_C2 = CW'(quant_e8(-64'sd58291000, F));
    localparam logic signed [CW-1:0] DEN_C0 = CW'(quant_e9(64'sd111082900, F));
    localparam logic signed [CW-1:0] DEN_C1 = CW'(quant_e9(-64'sd854058428, F));
    localparam logic signed [CW-1:0] DEN_C2 = CW'(quant_e9(64'sd522885000, F));
    localparam logic signed [CW-1:0] LUX_C0 = CW'(quant_e5(-64'sd32466, F));
    localparam logic signed [CW-1:0] LUX_C1 = CW'(quant_e5(64'sd157837, F));
    localparam logic signed [CW-1:0] LUX_C2 = CW'(quant_e5(-64'sd73191, F));
    localparam logic signed [CTW-1:0] CCT_C = CTW'(quant_e2(64'sd552033, F));
    localparam logic [NW-1:0]  N_SAT   = NW'(16) << F;
    localparam logic [2*NW-1:0]  HALF2 = (2*NW)'(1) << (F - 1);
    localparam logic [N2W+NW-1:0] HALF3 = (N2W + NW)'(1) << (F - 1);
    localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    // Stage 1: the nine coefficient products.
    logic                 s1_vld_reg;
    logic signed [PW-1:0] s1_num_reg [0:2];
    logic signed [PW-1:0] s1_den_reg [0:2];
    logic signed [PW-1:0] s1_lux_reg [0:2];
    logic signed [16:0]   smp [0:2];

    assign smp[0] = $signed(17'(s_red[SAMPLE_WIDTH-1:0]));
    assign smp[1] = $signed(17'(s_green[SAMPLE_WIDTH-1:0]));
    assign smp[2] = $signed(17'(s_blue[SAMPLE_WIDTH-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_num_reg[0] <= NUM_C0 * smp[0];
            s1_num_reg[1] <= NUM_C1 * smp[1];
            s1_num_reg[2] <= NUM_C2 * smp[2];
            s1_den_reg[0] <= DEN_C0 * smp[0];
            s1_den_reg[1] <= DEN_C1 * smp[1];
            s1_den_reg[2] <= DEN_C2 * smp[2];
            s1_lux_reg[0] <= LUX_C0 * smp[0];
            s1_lux_reg[1] <= LUX_C1 * smp[1];
            s1_lux_reg[2] <= LUX_C2 * smp[2];
        end
    end

    // Stage 2: the three linear forms.
    logic                 s2_vld_reg;
    logic signed [SW-1:0] s2_num_reg, s2_den_reg, s2_lux_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_num_reg <= SW'(s1_num_reg[0]) + SW'(s1_num_reg[1]) + SW'(s1_num_reg[2]);
            s2_den_reg <= SW'(s1_den_reg[0]) + SW'(s1_den_reg[1]) + SW'(s1_den_reg[2]);
            s2_lux_reg <= SW'(s1_lux_reg[0]) + SW'(s1_lux_reg[1]) + SW'(s1_lux_reg[2]);
        end
    end

    // Stage 3: magnitudes, flags and the saturated illuminance.
    logic [SW-1:0] nm, dm;
    logic [15:0]   lux_sat;
    logic          lux_clip;
    side_t         side3;

    assign nm = s2_num_reg[SW-1] ? SW'(-s2_num_reg) : SW'(s2_num_reg);
    assign dm = s2_den_reg[SW-1] ? SW'(-s2_den_reg) : SW'(s2_den_reg);

    always_comb begin
        lux_sat  = 16'd0;
        lux_clip = 1'b0;
        if (s2_lux_reg <= -(SW'(1) <<< F)) begin
            lux_clip = 1'b1;
        end else if (s2_lux_reg[SW-1]) begin
            lux_sat = 16'd0;
        end else if ((s2_lux_reg >>> F) > SW'(65535)) begin
            lux_sat  = 16'hFFFF;
            lux_clip = 1'b1;
        end else begin
            lux_sat = 16'(s2_lux_reg >>> F);
        end
        side3.inval = (dm == '0);
        side3.neg   = s2_num_reg[SW-1] ^ s2_den_reg[SW-1];
        side3.big   = {4'b0, nm} >= {dm, 4'b0};
        side3.lux   = lux_sat;
        side3.lclip = lux_clip;
    end

    // Divider: entry 0 is the stage-3 register, one quotient bit per later stage.
    logic          dv_vld_reg  [0:DS];
    logic [SW-1:0] dv_rem_reg  [0:DS];
    logic [SW-1:0] dv_dm_reg   [0:DS];
    logic [3:0]    dv_low_reg  [0:DS];
    logic [DS-1:0] dv_quo_reg  [0:DS];
    side_t         dv_side_reg [0:DS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0]  <= nm >> 4;
            dv_dm_reg[0]   <= dm;
            dv_low_reg[0]  <= nm[3:0];
            dv_quo_reg[0]  <= '0;
            dv_side_reg[0] <= side3;
        end
    end

    for (genvar j = 1; j <= DS; j++) begin : g_div
        logic          nb;
        logic [SW:0]   trial;
        logic          ge;

        if (j <= 4) begin : g_lo
            assign nb = dv_low_reg[j-1][4-j];
        end else begin : g_zero
            assign nb = 1'b0;
        end

        // Shift in one dividend bit and try the subtract.
        assign trial = {dv_rem_reg[j-1], nb};
        assign ge    = trial >= {1'b0, dv_dm_reg[j-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[j]  <= ge ? SW'(trial - {1'b0, dv_dm_reg[j-1]}) : SW'(trial);
                dv_dm_reg[j]   <= dv_dm_reg[j-1];
                dv_low_reg[j]  <= dv_low_reg[j-1];
                dv_quo_reg[j]  <= {dv_quo_reg[j-1][DS-2:0], ge};
                dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
    end

    // P1: square, integer part of 6823.3 n and the operand for the tenth.
    logic [NW-1:0] nmag;
    assign nmag = dv_side_reg[DS].big ? N_SAT : NW'(dv_quo_reg[DS]);

    logic            p1_vld_reg;
    side_t           p1_side_reg;
    logic [NW-1:0]   p1_n_reg;
    logic [2*NW-1:0] p1_sq_reg;
    logic [TW-1:0]   p1_ta_reg;
    logic [31:0]     p1_x3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= dv_vld_reg[DS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_side_reg <= dv_side_reg[DS];
            p1_n_reg    <= nmag;
            p1_sq_reg   <= (2*NW)'(nmag) * (2*NW)'(nmag);
            p1_ta_reg   <= TW'(nmag) * TW'(6823);
            p1_x3_reg   <= 32'(nmag) * 32'd3 + 32'd5;
        end
    end

    // P2: round n^2 and multiply by the reciprocal of ten.
    logic           p2_vld_reg;
    side_t          p2_side_reg;
    logic [NW-1:0]  p2_n_reg;
    logic [N2W-1:0] p2_n2_reg;
    logic [TW-1:0]  p2_ta_reg;
    logic [63:0]    p2_rc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (en) begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_side_reg <= p1_side_reg;
            p2_n_reg    <= p1_n_reg;
            p2_n2_reg   <= N2W'((p1_sq_reg + HALF2) >> F);
            p2_ta_reg   <= p1_ta_reg;
            p2_rc_reg   <= 64'(p1_x3_reg) * 64'(RECIP10);
        end
    end

    // P3: cube and the complete linear term.
    logic              p3_vld_reg;
    side_t             p3_side_reg;
    logic [N2W-1:0]    p3_n2_reg;
    logic [N2W+NW-1:0] p3_cube_reg;
    logic [TW-1:0]     p3_t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_vld_reg <= 1'b0;
        end else if (en) begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_side_reg <= p2_side_reg;
            p3_n2_reg   <= p2_n2_reg;
            p3_cube_reg <= (N2W + NW)'(p2_n2_reg) * (N2W + NW)'(p2_n_reg);
            p3_t_reg    <= p2_ta_reg + TW'(p2_rc_reg[63:35]);
        end
    end

    // P4: round n^3 and scale the cubic and square terms.
    logic           p4_vld_reg;
    side_t          p4_side_reg;
    logic [CTW-1:0] p4_c3_reg, p4_c2_reg;
    logic [TW-1:0]  p4_t_reg;
    logic [N3W-1:0] n3mag;

    assign n3mag = N3W'((p3_cube_reg + HALF3) >> F);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_vld_reg <= 1'b0;
        end else if (en) begin
            p4_vld_reg <= p3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_side_reg <= p3_side_reg;
            p4_c3_reg   <= CTW'(n3mag) * CTW'(449);
            p4_c2_reg   <= CTW'(p3_n2_reg) * CTW'(3525);
            p4_t_reg    <= p3_t_reg;
        end
    end

    // P5: signed polynomial sum.
    logic                  p5_vld_reg;
    side_t                 p5_side_reg;
    logic signed [CTW-1:0] p5_cct_reg;
    logic signed [CTW-1:0] c3s, ts;

    assign c3s = p4_side_reg.neg ? -$signed(p4_c3_reg) : $signed(p4_c3_reg);
    assign ts  = p4_side_reg.neg ? -$signed(CTW'(p4_t_reg)) : $signed(CTW'(p4_t_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_vld_reg <= 1'b0;
        end else if (en) begin
            p5_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_side_reg <= p4_side_reg;
            p5_cct_reg  <= c3s + $signed(p4_c2_reg) + ts + CCT_C;
        end
    end

    // Output register: saturate the temperature and apply the invalid case.
    logic [15:0] ct_next;
    logic        tclip_next;

    always_comb begin
        ct_next    = 16'd0;
        tclip_next = 1'b0;
        if (p5_side_reg.inval) begin
            ct_next = 16'd0;
        end else if (p5_cct_reg <= -(CTW'(1) <<< F)) begin
            tclip_next = 1'b1;
        end else if (p5_cct_reg[CTW-1]) begin
            ct_next = 16'd0;
        end else if ((p5_cct_reg >>> F) > CTW'(65535)) begin
            ct_next    = 16'hFFFF;
            tclip_next = 1'b1;
        end else begin
            ct_next = 16'(p5_cct_reg >>> F);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= p5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_color_temp   <= ct_next;
            m_lux          <= p5_side_reg.lux;
            m_temp_invalid <= p5_side_reg.inval;
            m_temp_clipped <= tclip_next;
            m_lux_clipped  <= p5_side_reg.lclip;
        end
    end

endmodule

`default_nettype wire
